// File: sv/ivpc_pkg.sv
// Package for the interrupt vector priority core.
// Holds the vector count, the operation and select codes, payload types and the
// processor priority function. No dependencies.
package ivpc_pkg;

    localparam int NUM_VECTORS = 256;
    localparam int VEC_W       = 8;
    localparam int WORD_W      = 32;
    localparam int WIDE_W      = 256;

    localparam logic [2:0] OP_RAISE = 3'd0;
    localparam logic [2:0] OP_EOI   = 3'd1;
    localparam logic [2:0] OP_TPR   = 3'd2;
    localparam logic [2:0] OP_ACK   = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [1:0] GRP_ISV  = 2'd0;
    localparam logic [1:0] GRP_TRIG = 2'd1;
    localparam logic [1:0] GRP_PIR  = 2'd2;
    localparam logic [4:0] SEL_TPR  = 5'd24;
    localparam logic [4:0] SEL_PPR  = 5'd25;

    localparam logic [0:0] CFG_ENABLE   = 1'b0;
    localparam logic [0:0] CFG_SPURIOUS = 1'b1;

    localparam logic [7:0] SPURIOUS_RESET = 8'hff;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] vector;
        logic       level_trigger;
        logic [7:0] priority_value;
        logic [4:0] word_select;
    } in_item_t;

    typedef struct packed {
        logic        delivered_valid;
        logic [7:0]  delivered_vector;
        logic [31:0] read_data;
        logic [7:0]  processor_priority;
    } out_item_t;

    typedef struct packed {
        logic       enable;
        logic [7:0] spurious;
    } cfg_t;

    // The task priority wins when its class is at least the in-service class.
    function automatic logic [7:0] ppr_calc(input logic [7:0] tpr, input logic [3:0] isv_class);
        logic [7:0] res;
        if (tpr[7:4] >= isv_class) begin
            res = tpr;
        end else begin
            res = {isv_class, 4'h0};
        end
        return res;
    endfunction

endpackage

// File: sv/interrupt_vector_priority_core_unit.sv
// Top level of the interrupt vector priority core: handshake, configuration and result register.
// Request and result are each registered; one request per cycle is taken unless m_ready stalls the result.
// The rate is set by the single pass through the priority encoders between input and result register.
// Reset (aresetn, synchronous, active low) clears all bitmaps, the task priority and enable.
// After reset the spurious vector is 255 and both channels are empty.
module interrupt_vector_priority_core_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ivpc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ivpc_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [7:0]          cfg_wdata
);

    ivpc_pkg::in_item_t  in_reg;
    ivpc_pkg::out_item_t out_reg;
    ivpc_pkg::out_item_t result;
    ivpc_pkg::cfg_t      cfg_reg;
    logic                in_valid_reg, out_valid_reg;
    logic                step;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    ivpc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            cfg_reg.enable   <= 1'b0;
            cfg_reg.spurious <= ivpc_pkg::SPURIOUS_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    ivpc_pkg::CFG_ENABLE:   cfg_reg.enable   <= cfg_wdata[0];
                    ivpc_pkg::CFG_SPURIOUS: cfg_reg.spurious <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (step) begin
            out_reg <= result;
        end
    end

    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("a processed request did not produce a result");

    a_no_vector_without_delivery: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.delivered_valid) |-> (m_data.delivered_vector == 8'h00))
        else $error("delivered vector is nonzero without a delivery");

    a_held_request_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_reg)))
        else $error("a pending request was lost or changed while stalled");

endmodule

// File: sv/ivpc_prio_enc.sv
// Highest-set-bit encoder over the vector bitmap.
// Depends on ivpc_pkg for the vector count and index width.
module ivpc_prio_enc (
    input  logic [ivpc_pkg::NUM_VECTORS-1:0] bits_in,
    output logic                             found,
    output logic [ivpc_pkg::VEC_W-1:0]       idx
);

    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < ivpc_pkg::NUM_VECTORS; i++) begin
            if (bits_in[i]) begin
                found = 1'b1;
                idx   = ivpc_pkg::VEC_W'(i);
            end
        end
    end

endmodule

// File: sv/ivpc_core.sv
// Priority state and single-pass step logic of the interrupt vector priority core.
// Depends on ivpc_pkg and ivpc_prio_enc.
module ivpc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  ivpc_pkg::in_item_t  item,
    input  ivpc_pkg::cfg_t      cfg,
    output ivpc_pkg::out_item_t result
);

    localparam int N = ivpc_pkg::NUM_VECTORS;

    logic [N-1:0] pir_reg, pir_next, pir_pre;
    logic [N-1:0] isv_reg, isv_next, isv_pre;
    logic [N-1:0] trig_reg, trig_next;
    logic [7:0]   tpr_reg, tpr_next;

    logic         isv_found, isv_pre_found, pend_found;
    logic [7:0]   isv_idx, isv_pre_idx, pend_idx;
    logic [3:0]   isv_pre_class, isv_post_class;
    logic [7:0]   ppr_pre, ppr_post;
    logic [N-1:0] raise_oh, eoi_oh, pend_oh;
    logic         raise_hit, masked, deliverable, do_accept, do_spurious;
    logic [2:0]   op;
    logic [4:0]   sel;
    logic [ivpc_pkg::WIDE_W-1:0] isv_wide, trig_wide, pir_wide;
    logic [31:0]  rdata;

    ivpc_prio_enc u_isv_enc (.bits_in(isv_reg), .found(isv_found), .idx(isv_idx));
    ivpc_prio_enc u_isv_pre_enc (.bits_in(isv_pre), .found(isv_pre_found), .idx(isv_pre_idx));
    ivpc_prio_enc u_pend_enc (.bits_in(pir_pre), .found(pend_found), .idx(pend_idx));

    assign op  = item.operation;
    assign sel = item.word_select;

    assign raise_hit = (op == ivpc_pkg::OP_RAISE) && ({1'b0, item.vector} < 9'(N));
    assign raise_oh  = raise_hit ? (N'(1) << item.vector) : '0;
    assign eoi_oh    = ((op == ivpc_pkg::OP_EOI) && isv_found) ? (N'(1) << isv_idx) : '0;

    assign pir_pre  = pir_reg | raise_oh;
    assign isv_pre  = isv_reg & ~eoi_oh;
    assign tpr_next = (op == ivpc_pkg::OP_TPR) ? item.priority_value : tpr_reg;

    assign isv_pre_class = isv_pre_found ? isv_pre_idx[7:4] : 4'h0;
    assign ppr_pre       = ivpc_pkg::ppr_calc(tpr_next, isv_pre_class);

    assign masked      = (ppr_pre != 8'h00) && (pend_idx[7:4] <= ppr_pre[7:4]);
    assign deliverable = cfg.enable && pend_found && !masked;
    assign do_accept   = deliverable && (op <= ivpc_pkg::OP_ACK);
    assign do_spurious = cfg.enable && pend_found && masked && (op == ivpc_pkg::OP_ACK);

    assign pend_oh   = do_accept ? (N'(1) << pend_idx) : '0;
    assign pir_next  = pir_pre & ~pend_oh;
    assign isv_next  = isv_pre | pend_oh;
    assign trig_next = (trig_reg & ~raise_oh) | (item.level_trigger ? raise_oh : '0);

    // An accepted vector only ever raises the in-service class.
    always_comb begin
        isv_post_class = isv_pre_class;
        if (do_accept && (pend_idx[7:4] > isv_pre_class)) begin
            isv_post_class = pend_idx[7:4];
        end
    end
    assign ppr_post = ivpc_pkg::ppr_calc(tpr_next, isv_post_class);

    assign isv_wide  = ivpc_pkg::WIDE_W'(isv_reg);
    assign trig_wide = ivpc_pkg::WIDE_W'(trig_reg);
    assign pir_wide  = ivpc_pkg::WIDE_W'(pir_reg);

    always_comb begin
        rdata = '0;
        if (op == ivpc_pkg::OP_READ) begin
            case (sel[4:3])
                ivpc_pkg::GRP_ISV:  rdata = isv_wide[{sel[2:0], 5'b0} +: 32];
                ivpc_pkg::GRP_TRIG: rdata = trig_wide[{sel[2:0], 5'b0} +: 32];
                ivpc_pkg::GRP_PIR:  rdata = pir_wide[{sel[2:0], 5'b0} +: 32];
                default: begin
                    if (sel == ivpc_pkg::SEL_TPR) begin
                        rdata = {24'h0, tpr_reg};
                    end else if (sel == ivpc_pkg::SEL_PPR) begin
                        rdata = {24'h0, ppr_pre};
                    end
                end
            endcase
        end
    end

    always_comb begin
        result.delivered_valid    = do_accept || do_spurious;
        result.delivered_vector   = do_accept ? pend_idx : (do_spurious ? cfg.spurious : 8'h00);
        result.read_data          = rdata;
        result.processor_priority = ppr_post;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pir_reg  <= '0;
            isv_reg  <= '0;
            trig_reg <= '0;
            tpr_reg  <= '0;
        end else if (step) begin
            pir_reg  <= pir_next;
            isv_reg  <= isv_next;
            trig_reg <= trig_next;
            tpr_reg  <= tpr_next;
        end
    end

endmodule
